// ===== rtl/ttce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text terminal character engine package
// Shared widths, character codes, colors and types of the character engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

  localparam int unsigned COL_W       = 8;
  localparam int unsigned ROW_W       = 7;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned CFG_COLS_W  = 9;
  localparam int unsigned CFG_ROWS_W  = 8;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned SEQ_CNT_W   = 3;
  localparam int unsigned TDATA_W     = 48;

  localparam int unsigned MAX_COLS    = 256;
  localparam int unsigned MAX_ROWS    = 128;

  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 9'd80;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 8'd25;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_CSI   = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SGR   = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_RED   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_GREEN = 8'h32;
  localparam logic [CHAR_W-1:0] CH_YELLOW = 8'h33;
  localparam logic [CHAR_W-1:0] CH_BLUE  = 8'h34;
  localparam logic [CHAR_W-1:0] CH_CYAN  = 8'h36;

  // "1;3" prefix of a bold color sequence, oldest byte highest
  localparam logic [23:0] SGR_BOLD_PREFIX = 24'h313B33;
  localparam logic [SEQ_CNT_W-1:0] SEQ_CNT_MAX = 3'd5;

  localparam logic [COLOR_W-1:0] COLOR_RED    = 24'hFF3333;
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 24'h33FF33;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF33;
  localparam logic [COLOR_W-1:0] COLOR_BLUE   = 24'h3388FF;
  localparam logic [COLOR_W-1:0] COLOR_CYAN   = 24'h33FFFF;
  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ESC_IDLE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_COLLECT = 2'd2
  } esc_phase_e;

  typedef enum logic {
    KIND_CELL   = 1'b0,
    KIND_SCROLL = 1'b1
  } res_kind_e;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_COLS_W-1:0] cols;
    logic [CFG_ROWS_W-1:0] rows;
  } cfg_t;

  typedef struct packed {
    res_kind_e            kind;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [CHAR_W-1:0]    chr;
    logic [COLOR_W-1:0]   color;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/text_terminal_char_engine.sv =====
// ----------------------------------------------------------------------------
// Text terminal character engine
// Parses a character stream with color escape sequences and emits cell
// writes and scroll requests for a text console.
// An accepted byte waits in the input register; its results go into the
// result queue once the queue has room. Throughput: one byte per cycle
// while the output is ready and each byte causes at most one result; a byte
// that causes both a cell write and a scroll holds back the next byte while
// its cell write leaves, set by the one output port of the two-entry queue.
// Reset: cursor at column 0, row 0, color white, no sequence open, queue
// empty, screen 80 x 25.
// ----------------------------------------------------------------------------
module text_terminal_char_engine #(
  parameter int unsigned MaxCols = ttce_pkg::MAX_COLS,
  parameter int unsigned MaxRows = ttce_pkg::MAX_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [ttce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,   // [7:0] char_byte
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] cell_col, [14:8] cell_row, [22:15] cell_char, [46:23] cell_color,
  // [47] zero
  output logic [ttce_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  output logic [0:0]                      m_axis_tuser_o,   // [0] res_kind
  output logic                            m_axis_tlast_o
);
  import ttce_pkg::*;

  cfg_t cfg;

  ttce_cfg #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // Input register
  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] in_byte_q;
  logic              in_accept;
  logic              fire;
  logic [CHAR_W-1:0] b;

  // Console state
  esc_phase_e           phase_q, phase_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic [SEQ_W-1:0]     seq_q, seq_d;
  logic [SEQ_CNT_W-1:0] seq_cnt_q, seq_cnt_d;

  // Result queue
  result_t    slot_q [2];
  result_t    slot_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  // Step logic
  logic               ordinary;
  logic [ROW_W:0]     nl_inc;
  logic               nl_scroll;
  logic [ROW_W-1:0]   nl_row;
  logic               in_screen;
  logic [COL_W:0]     col_adv;
  logic               wrap;
  logic               do_write;
  logic               do_scroll;
  logic [COL_W-1:0]   wr_col;
  logic [CHAR_W-1:0]  wr_char;
  logic               sgr_hit;
  logic [COLOR_W-1:0] sgr_color;
  result_t            res0, res1;
  logic [1:0]         n_res;

  assign b         = in_byte_q;
  assign pop       = m_axis_tvalid_o && m_axis_tready_i;
  // The step fires only when the queue will be empty, so both results fit.
  assign fire      = in_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // Escape parser next state
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      case (phase_q)
        ESC_COLLECT: if (b == CH_SGR) phase_d = ESC_IDLE;
        ESC_SEEN:    phase_d = (b == CH_CSI) ? ESC_COLLECT : ESC_IDLE;
        ESC_IDLE:    if (b == CH_ESC) phase_d = ESC_SEEN;
        default:     phase_d = ESC_IDLE;
      endcase
    end
  end

  // A byte after a lone ESC is printed as usual, even another ESC.
  assign ordinary = ((phase_q == ESC_SEEN) && (b != CH_CSI)) ||
                    ((phase_q == ESC_IDLE) && (b != CH_ESC));

  // Decode a finished color sequence
  always_comb begin
    sgr_hit   = 1'b0;
    sgr_color = color_q;
    if ((seq_cnt_q == 3'd1) && (seq_q[7:0] == CH_ZERO)) begin
      sgr_hit   = 1'b1;
      sgr_color = COLOR_WHITE;
    end else if ((seq_cnt_q == 3'd4) && (seq_q[31:8] == SGR_BOLD_PREFIX)) begin
      sgr_hit = 1'b1;
      case (seq_q[7:0])
        CH_RED:    sgr_color = COLOR_RED;
        CH_GREEN:  sgr_color = COLOR_GREEN;
        CH_YELLOW: sgr_color = COLOR_YELLOW;
        CH_BLUE:   sgr_color = COLOR_BLUE;
        CH_CYAN:   sgr_color = COLOR_CYAN;
        default:   sgr_hit   = 1'b0;
      endcase
    end
  end

  // Next-line move, shared by newline and wrap
  assign nl_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
  assign nl_scroll = (nl_inc >= cfg.rows);
  assign nl_row    = nl_scroll ? ROW_W'(cfg.rows - CFG_ROWS_W'(1)) : nl_inc[ROW_W-1:0];

  assign in_screen = ({1'b0, col_q} < cfg.cols) && ({1'b0, row_q} < cfg.rows);
  assign col_adv   = {1'b0, col_q} + {{COL_W{1'b0}}, in_screen};
  assign wrap      = (col_adv >= cfg.cols);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    color_d   = color_q;
    seq_d     = seq_q;
    seq_cnt_d = seq_cnt_q;
    do_write  = 1'b0;
    do_scroll = 1'b0;
    wr_col    = col_q;
    wr_char   = b;
    if (fire) begin
      case (phase_q)
        ESC_COLLECT: begin
          if (b == CH_SGR) begin
            if (sgr_hit) color_d = sgr_color;
            seq_d     = '0;
            seq_cnt_d = '0;
          end else begin
            seq_d = {seq_q[SEQ_W-CHAR_W-1:0], b};
            if (seq_cnt_q < SEQ_CNT_MAX) seq_cnt_d = seq_cnt_q + SEQ_CNT_W'(1);
          end
        end
        ESC_SEEN: begin
          if (b == CH_CSI) begin
            seq_d     = '0;
            seq_cnt_d = '0;
          end
        end
        default: ;
      endcase

      if (ordinary) begin
        if (b == CH_LF) begin
          col_d     = '0;
          row_d     = nl_row;
          do_scroll = nl_scroll;
        end else if (b == CH_BS) begin
          if (col_q != '0) begin
            col_d    = col_q - COL_W'(1);
            wr_col   = col_q - COL_W'(1);
            wr_char  = CH_SPACE;
            do_write = 1'b1;
          end
        end else begin
          do_write = in_screen && (b != CH_CR);
          if (wrap) begin
            col_d     = '0;
            row_d     = nl_row;
            do_scroll = nl_scroll;
          end else begin
            col_d = col_adv[COL_W-1:0];
          end
        end
      end
    end
  end

  // Results: a cell write always comes before a scroll.
  always_comb begin
    res0 = '0;
    res1 = '0;
    if (do_write) begin
      res0.kind  = KIND_CELL;
      res0.col   = wr_col;
      res0.row   = row_q;
      res0.chr   = wr_char;
      res0.color = color_q;
      res0.last  = !do_scroll;
    end else begin
      res0.kind = KIND_SCROLL;
      res0.last = 1'b1;
    end
    res1.kind = KIND_SCROLL;
    res1.last = 1'b1;
    n_res = {1'b0, do_write} + {1'b0, do_scroll};
  end

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    cnt_d     = cnt_q;
    if (fire) begin
      slot_d[0] = res0;
      slot_d[1] = res1;
      cnt_d     = n_res;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= ESC_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      color_q    <= COLOR_WHITE;
      seq_q      <= '0;
      seq_cnt_q  <= '0;
      cnt_q      <= 2'd0;
    end else begin
      in_valid_q <= in_valid_d;
      phase_q    <= phase_d;
      col_q      <= col_d;
      row_q      <= row_d;
      color_q    <= color_d;
      seq_q      <= seq_d;
      seq_cnt_q  <= seq_cnt_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_byte_q <= s_axis_tdata_i;
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {1'b0, slot_q[0].color, slot_q[0].chr, slot_q[0].row,
                            slot_q[0].col};
  assign m_axis_tuser_o  = slot_q[0].kind;
  assign m_axis_tlast_o  = slot_q[0].last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!slot_q[0].last && slot_q[1].last &&
                         slot_q[1].kind == KIND_SCROLL))
    else $error("queued result pair is not a cell write followed by a scroll");

  a_scroll_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_SCROLL) |->
      (m_axis_tdata_o == '0 && m_axis_tlast_o))
    else $error("scroll result carries cell fields or is not last");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted byte not held in the input register");

endmodule

// ===== rtl/ttce_cfg.sv =====
// ----------------------------------------------------------------------------
// Text terminal character engine configuration registers
// Holds the screen size registers; saturates writes, rows from the low 8 bits.
// ----------------------------------------------------------------------------
module ttce_cfg #(
  parameter int unsigned MaxCols = ttce_pkg::MAX_COLS,
  parameter int unsigned MaxRows = ttce_pkg::MAX_ROWS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_index_i,
  input  logic [ttce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ttce_pkg::cfg_t                 cfg_o
);
  import ttce_pkg::*;

  localparam logic [CFG_COLS_W-1:0] ColsLimit = CFG_COLS_W'(MaxCols);
  localparam logic [CFG_ROWS_W-1:0] RowsLimit = CFG_ROWS_W'(MaxRows);

  cfg_t                  cfg_q, cfg_d;
  logic [CFG_COLS_W-1:0] cols_sat;
  logic [CFG_ROWS_W-1:0] rows_sat;
  logic [CFG_ROWS_W-1:0] rows_raw;

  assign rows_raw = cfg_data_i[CFG_ROWS_W-1:0];

  always_comb begin
    if (cfg_data_i == '0) begin
      cols_sat = CFG_COLS_W'(1);
    end else if (cfg_data_i > ColsLimit) begin
      cols_sat = ColsLimit;
    end else begin
      cols_sat = cfg_data_i;
    end
    if (rows_raw == '0) begin
      rows_sat = CFG_ROWS_W'(1);
    end else if (rows_raw > RowsLimit) begin
      rows_sat = RowsLimit;
    end else begin
      rows_sat = rows_raw;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLS: cfg_d.cols = cols_sat;
        CFG_ROWS: cfg_d.rows = rows_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols <= COLS_RESET;
      cfg_q.rows <= ROWS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== tb/tb_text_terminal_char_engine.sv =====
// ----------------------------------------------------------------------------
// Testbench for the text terminal character engine
// Streams character bytes into the engine and checks every cell write and
// scroll request against a cycle-free model of the cursor, the color and the
// escape parser. Screen sizes are changed between phases while the engine is
// idle, and both stream sides stall at random unless a phase turns that off.
// ----------------------------------------------------------------------------
module tb_text_terminal_char_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ttce_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned LONG_HOLD  = 250;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [TDATA_W-1:0]    m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  text_terminal_char_engine DUT (.*);

  // Console model state
  int unsigned        scr_cols;
  int unsigned        scr_rows;
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] cur_color;
  esc_phase_e         esc_state;
  logic [SEQ_W-1:0]   seq_buf;
  logic [SEQ_CNT_W-1:0] seq_len;

  logic [7:0] pending_bytes[$];
  result_t    due_results[$];

  int  fail_cnt = 0;
  int  idle_cycles = 0;
  bit  idling_on = 1'b1;
  int  holds_asked = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  logic in_fire = 1'b0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic void push_result(res_kind_e kind, int unsigned col, int unsigned row,
                                      logic [7:0] chr, logic [COLOR_W-1:0] color);
    result_t r;
    r.kind  = kind;
    r.col   = col[COL_W-1:0];
    r.row   = row[ROW_W-1:0];
    r.chr   = chr;
    r.color = color;
    r.last  = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void line_feed();
    int unsigned row;
    row = cur_row + 1;
    cur_col = 0;
    if (row >= scr_rows) begin
      row = scr_rows - 1;
      push_result(KIND_SCROLL, 0, 0, '0, '0);
    end
    cur_row = row & 32'h7F;
  endfunction

  // Works out the cell writes and scrolls that one accepted byte causes.
  function automatic void predict_char(logic [7:0] b);
    int unsigned nxt;
    int          n0;
    n0 = due_results.size();
    if (esc_state == ESC_COLLECT) begin
      if (b == CH_SGR) begin
        if (seq_len == 3'd1 && seq_buf[7:0] == CH_ZERO) begin
          cur_color = COLOR_WHITE;
        end else if (seq_len == 3'd4 && seq_buf[31:8] == SGR_BOLD_PREFIX) begin
          case (seq_buf[7:0])
            CH_RED:    cur_color = COLOR_RED;
            CH_GREEN:  cur_color = COLOR_GREEN;
            CH_YELLOW: cur_color = COLOR_YELLOW;
            CH_BLUE:   cur_color = COLOR_BLUE;
            CH_CYAN:   cur_color = COLOR_CYAN;
            default: ;
          endcase
        end
        esc_state = ESC_IDLE;
        seq_buf = '0;
        seq_len = '0;
      end else begin
        seq_buf = {seq_buf[SEQ_W-9:0], b};
        if (seq_len < SEQ_CNT_MAX) seq_len++;
      end
      return;
    end
    if (esc_state == ESC_SEEN) begin
      // A lone ESC is dropped and this byte is taken as ordinary, even ESC.
      esc_state = ESC_IDLE;
      if (b == CH_CSI) begin
        esc_state = ESC_COLLECT;
        seq_buf = '0;
        seq_len = '0;
        return;
      end
    end else if (b == CH_ESC) begin
      esc_state = ESC_SEEN;
      return;
    end

    if (b == CH_LF) begin
      line_feed();
    end else if (b == CH_BS) begin
      if (cur_col > 0) begin
        cur_col--;
        push_result(KIND_CELL, cur_col, cur_row, CH_SPACE, cur_color);
      end
    end else begin
      // A cursor outside a shrunk screen writes nothing; it wraps if past the last column, else stays put.
      nxt = cur_col;
      if (cur_col < scr_cols && cur_row < scr_rows) begin
        if (b != CH_CR) push_result(KIND_CELL, cur_col, cur_row, b, cur_color);
        nxt++;
      end
      if (nxt >= scr_cols) line_feed();
      else cur_col = nxt & 32'hFF;
    end
    if (due_results.size() > n0) due_results[$].last = 1'b1;
  endfunction

  // Input side: prediction at the edge, driving at the falling edge.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) predict_char(s_axis_tdata_i);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!(s_axis_tvalid_i && !in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        s_axis_tdata_i  <= pending_bytes.pop_front();
        s_axis_tvalid_i <= 1'b1;
        if (idling_on && $urandom_range(0, 2) == 0) tx_gap = pick_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Output side: ready with random stalls and, on request, one long hold.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (idling_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  function automatic void note_failure(string what, result_t want, result_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind %0d col %0d row %0d char %h color %h last %0d",
               want.kind, want.col, want.row, want.chr, want.color, want.last);
      $display("  actual   kind %0d col %0d row %0d char %h color %h last %0d",
               got.kind, got.col, got.row, got.chr, got.color, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind  = res_kind_e'(m_axis_tuser_o[0]);
      got.col   = m_axis_tdata_o[7:0];
      got.row   = m_axis_tdata_o[14:8];
      got.chr   = m_axis_tdata_o[22:15];
      got.color = m_axis_tdata_o[46:23];
      got.last  = m_axis_tlast_o;
      if (due_results.size() == 0) begin
        want = '0;
        note_failure("result with none expected", want, got);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.col !== want.col || got.row !== want.row ||
            got.chr !== want.chr || got.color !== want.color || got.last !== want.last ||
            m_axis_tdata_o[47] !== 1'b0)
          note_failure("result mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    int unsigned v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_COLS) begin
      v = val;
      if (v < 1) v = 1;
      if (v > MAX_COLS) v = MAX_COLS;
      scr_cols = v;
    end else begin
      v = val[7:0];
      if (v < 1) v = 1;
      if (v > MAX_ROWS) v = MAX_ROWS;
      scr_rows = v;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every byte is taken and every result has come out, then lets
  // bytes that cause no result leave the pipeline.
  task automatic drain();
    while (pending_bytes.size() > 0 || s_axis_tvalid_i || due_results.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic fill_random(int n, int lf_pct);
    string good_sgr[6];
    int    start;
    int    r;
    int    len;
    good_sgr = '{"0", "1;31", "1;32", "1;33", "1;34", "1;36"};
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n) begin
      r = $urandom_range(0, 99);
      if (r < lf_pct) begin
        pending_bytes.push_back(CH_LF);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 65) begin
        pending_bytes.push_back(CH_BS);
      end else if (r < 70) begin
        pending_bytes.push_back(CH_CR);
      end else if (r < 88) begin
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_CSI);
        push_text(good_sgr[$urandom_range(0, 5)]);
        pending_bytes.push_back(CH_SGR);
      end else if (r < 95) begin
        // Unsupported, truncated, overlong or garbage sequence bodies.
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(CH_CSI);
        case ($urandom_range(0, 3))
          0: begin
            len = $urandom_range(0, 6);
            repeat (len) pending_bytes.push_back(8'($urandom_range(0, 255)));
          end
          1: begin
            push_text("1;3");
            pending_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
          end
          2: push_text("01;31");
          default: begin
            push_text("1;3");
            pending_bytes.push_back(CH_ESC);
          end
        endcase
        pending_bytes.push_back(CH_SGR);
      end else begin
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back($urandom_range(0, 1) ? CH_ESC : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows,
                           int n, int lf_pct, bit idle_en);
    drain();
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    idling_on = idle_en;
    fill_random(n / 2, lf_pct);
    // The sender pauses here until all results of the first half are in.
    drain();
    fill_random(n - n / 2, lf_pct);
  endtask

  initial begin
    logic [7:0] opening[$];
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_COLS;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;

    scr_cols  = COLS_RESET;
    scr_rows  = ROWS_RESET;
    cur_col   = 0;
    cur_row   = 0;
    cur_color = COLOR_WHITE;
    esc_state = ESC_IDLE;
    seq_buf   = '0;
    seq_len   = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Byte extremes, carriage return, backspace, a lone ESC before a letter
    // and before another ESC, green, reset to white, newline, backspace at
    // column zero.
    opening = '{8'h00, 8'hFF, CH_CR, CH_BS, CH_ESC, 8'h58, CH_ESC, CH_ESC,
                CH_ESC, CH_CSI, 8'h31, 8'h3B, 8'h33, CH_GREEN, CH_SGR, 8'h67,
                CH_ESC, CH_CSI, CH_ZERO, CH_SGR, CH_LF, CH_BS, 8'h7F};
    foreach (opening[i]) pending_bytes.push_back(opening[i]);
    fill_random(150, 15);
    // Long stall on the output while the input keeps offering bytes.
    holds_asked++;

    run_phase(9'd0,   9'd0,   140, 20, 1'b1);
    run_phase(9'd511, 9'd511, 300, 55, 1'b1);
    run_phase(9'd8,   9'd4,   140, 10, 1'b1);
    run_phase(9'd256, 9'd128, 100, 20, 1'b1);
    run_phase(9'd1,   9'd128, 100, 10, 1'b0);
    run_phase(9'h100, 9'h100, 100, 10, 1'b1);
    run_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 120, 15, 1'b1);

    drain();
    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
